@@ hw/rtl/dbs_pkg.sv @@
// Shared types and constants for the debounced button scanner.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package dbs_pkg;

    // Number of contacts carried in the level and fault fields.
    localparam int LINE_N = 5;
    // Width of the scan position, start pointer and active count.
    localparam int SCAN_W = 3;
    // Width of the configuration write data (widest register).
    localparam int CFG_W = 5;
    // Width of the configuration register index.
    localparam int CFG_AW = 2;
    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_AW-1:0] {
        REG_ACTIVE_SOURCES    = 2'd0,
        REG_ENABLE_MASK       = 2'd1,
        REG_CENTRE_ACTIVE_LOW = 2'd2,
        REG_DIRECTION_MAP     = 2'd3
    } cfg_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted request and set up the scan
        logic seed;   // copy current pressed state into the debounce state
        logic step;   // debounce one contact of the scan
        logic push;   // move the result into the output register
    } dbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;       // the contact of this step shows a confirmed press
        logic last;      // this step visits the last contact of the scan
        logic out_free;  // the output register can take a result now
    } dbs_status_t;

endpackage : dbs_pkg

`default_nettype wire

@@ hw/rtl/dbs_ctrl.sv @@
// Sequencing controller for the debounced button scanner.
// Depends on dbs_pkg for the command and status structs.
`default_nettype none

module dbs_ctrl
    import dbs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_kind,
    output logic             s_tready,
    input  dbs_status_t      stat,
    output dbs_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEED   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = s_kind ? ST_SEED : ST_SCAN;
                end
            end
            ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.hit || stat.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : dbs_ctrl

`default_nettype wire

@@ hw/rtl/dbs_datapath.sv @@
// Datapath of the debounced button scanner: configuration registers,
// per-contact debounce state, scan pointers and the output register.
// Depends on dbs_pkg for widths, register indexes and the control structs.
`default_nettype none

module dbs_datapath
    import dbs_pkg::*;
#(
    parameter int NUM_SOURCES   = 5,
    parameter int AGREE_SAMPLES = 3
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CFG_AW-1:0]   cfg_addr,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    input  wire logic                in_kind,
    input  wire logic [LINE_N-1:0]   in_levels,
    input  wire logic [LINE_N-1:0]   in_fault,
    input  dbs_cmd_t                 cmd,
    output dbs_status_t              stat,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata
);

    // Contacts beyond the field width never change state, so only the
    // first few carry storage.
    localparam int STORE_N = (NUM_SOURCES < LINE_N) ? NUM_SOURCES : LINE_N;
    localparam int STORE_W = (STORE_N > 1) ? $clog2(STORE_N) : 1;
    localparam int AGR_W   = $clog2(AGREE_SAMPLES + 1);
    localparam logic [AGR_W-1:0]  AGR_FULL = AGR_W'(AGREE_SAMPLES);
    localparam logic [AGR_W-1:0]  AGR_ONE  = AGR_W'(1);
    localparam logic [SCAN_W-1:0] CNT_CAP  =
        (NUM_SOURCES > 7) ? SCAN_W'(7) : SCAN_W'(NUM_SOURCES);

    // Remainder of a narrow value by a count of at least one.
    function automatic logic [SCAN_W-1:0] wrap_mod(
        input logic [SCAN_W-1:0] val,
        input logic [SCAN_W-1:0] cnt
    );
        logic [SCAN_W-1:0] r;
        r = val;
        for (int k = 0; k < 7; k++)
        begin
            if (r >= cnt)
            begin
                r = r - cnt;
            end
        end
        return r;
    endfunction

    // A bit of a contact field; contacts past the field read as zero.
    function automatic logic line_bit(
        input logic [LINE_N-1:0] word,
        input logic [SCAN_W-1:0] idx
    );
        logic b;
        b = 1'b0;
        if (32'(idx) < LINE_N)
        begin
            b = word[idx];
        end
        return b;
    endfunction

    // Configuration registers.
    logic [SCAN_W-1:0] active_reg;
    logic [LINE_N-1:0] enable_reg;
    logic              cal_reg;
    logic [LINE_N-1:0] dir_map_reg;

    // Debounce state.
    logic [STORE_N-1:0] stable_reg,    stable_next;
    logic [STORE_N-1:0] cand_reg,      cand_next;
    logic [AGR_W-1:0]   agree_reg      [STORE_N];
    logic [AGR_W-1:0]   agree_next     [STORE_N];
    logic [SCAN_W-1:0]  start_reg,     start_next;

    // Captured request and scan position.
    logic [LINE_N-1:0]  levels_reg,    levels_next;
    logic [LINE_N-1:0]  fault_reg,     fault_next;
    logic [SCAN_W-1:0]  pos_reg,       pos_next;
    logic [SCAN_W-1:0]  visit_reg,     visit_next;

    // Pending result and output register.
    logic               ev_valid_reg,  ev_valid_next;
    logic               ev_dir_reg,    ev_dir_next;
    logic [SCAN_W-1:0]  ev_src_reg,    ev_src_next;
    logic               out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic [SCAN_W-1:0]  count;
    logic [SCAN_W-1:0]  pos_inc;
    logic               pos_live;
    logic [STORE_W-1:0] sidx;
    logic               now_pressed;
    logic [AGR_W-1:0]   agree_cur;
    logic [AGR_W-1:0]   agree_inc;
    logic               hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= SCAN_W'(1);
            enable_reg  <= '0;
            cal_reg     <= 1'b0;
            dir_map_reg <= LINE_N'(24);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ACTIVE_SOURCES:    active_reg  <= cfg_wdata[SCAN_W-1:0];
                REG_ENABLE_MASK:       enable_reg  <= cfg_wdata[LINE_N-1:0];
                REG_CENTRE_ACTIVE_LOW: cal_reg     <= cfg_wdata[0];
                REG_DIRECTION_MAP:     dir_map_reg <= cfg_wdata[LINE_N-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        if (active_reg == '0)
        begin
            count = SCAN_W'(1);
        end
        else if (active_reg > CNT_CAP)
        begin
            count = CNT_CAP;
        end
        else
        begin
            count = active_reg;
        end
    end

    // One contact per step: the shared sample-and-settle logic.
    always_comb
    begin
        pos_inc     = (pos_reg + SCAN_W'(1) == count) ? '0 : pos_reg + SCAN_W'(1);
        pos_live    = (32'(pos_reg) < STORE_N) && line_bit(enable_reg, pos_reg);
        sidx        = pos_live ? pos_reg[STORE_W-1:0] : '0;
        now_pressed = !line_bit(fault_reg, pos_reg) &&
                      (line_bit(levels_reg, pos_reg) ^ (cal_reg && pos_reg == '0));
        agree_cur   = agree_reg[sidx];
        agree_inc   = (agree_cur < AGR_FULL) ? agree_cur + AGR_ONE : agree_cur;
        hit         = pos_live && now_pressed == cand_reg[sidx] &&
                      agree_inc >= AGR_FULL && now_pressed != stable_reg[sidx] &&
                      now_pressed;
    end

    assign stat.hit      = cmd.step && hit;
    assign stat.last     = (visit_reg + SCAN_W'(1) == count);
    assign stat.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        stable_next    = stable_reg;
        cand_next      = cand_reg;
        agree_next     = agree_reg;
        start_next     = start_reg;
        levels_next    = levels_reg;
        fault_next     = fault_reg;
        pos_next       = pos_reg;
        visit_next     = visit_reg;
        ev_valid_next  = ev_valid_reg;
        ev_dir_next    = ev_dir_reg;
        ev_src_next    = ev_src_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            levels_next   = in_levels;
            fault_next    = in_fault;
            pos_next      = wrap_mod(start_reg, count);
            visit_next    = '0;
            ev_valid_next = 1'b0;
            ev_dir_next   = 1'b0;
            ev_src_next   = '0;
        end

        if (cmd.seed)
        begin
            for (int k = 0; k < STORE_N; k++)
            begin
                if (k < 32'(count) && enable_reg[k])
                begin
                    stable_next[k] = !fault_reg[k] &&
                                     (levels_reg[k] ^ (cal_reg && k == 0));
                    cand_next[k]   = stable_next[k];
                    agree_next[k]  = AGR_FULL;
                end
            end
        end

        if (cmd.step)
        begin
            if (pos_live)
            begin
                if (now_pressed != cand_reg[sidx])
                begin
                    cand_next[sidx]  = now_pressed;
                    agree_next[sidx] = AGR_ONE;
                end
                else
                begin
                    agree_next[sidx] = agree_inc;
                    // A confirmed level, press or release, becomes the
                    // stable one.
                    if (agree_inc >= AGR_FULL)
                    begin
                        stable_next[sidx] = now_pressed;
                    end
                end
            end
            if (hit)
            begin
                ev_valid_next = 1'b1;
                ev_dir_next   = line_bit(dir_map_reg, pos_reg);
                ev_src_next   = pos_reg;
                start_next    = pos_inc;
            end
            pos_next   = pos_inc;
            visit_next = visit_reg + SCAN_W'(1);
        end

        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = M_DATA_W'({ev_src_reg, ev_dir_reg, ev_valid_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg    <= '0;
            cand_reg      <= '0;
            for (int k = 0; k < STORE_N; k++)
            begin
                agree_reg[k] <= '0;
            end
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stable_reg    <= stable_next;
            cand_reg      <= cand_next;
            agree_reg     <= agree_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        levels_reg   <= levels_next;
        fault_reg    <= fault_next;
        pos_reg      <= pos_next;
        visit_reg    <= visit_next;
        ev_valid_reg <= ev_valid_next;
        ev_dir_reg   <= ev_dir_next;
        ev_src_reg   <= ev_src_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The request kind is decoded by the controller; the datapath only
    // needs the levels and faults.
    logic unused_kind;
    assign unused_kind = in_kind;

endmodule : dbs_datapath

`default_nettype wire

@@ hw/rtl/debounced_button_scanner.sv @@
// Top level of the debounced button scanner.
// Instantiates dbs_ctrl and dbs_datapath; depends on dbs_pkg.
`default_nettype none

// The scanner debounces up to five push contacts and reports at most one
// confirmed press per poll request. Each input request carries the sampled
// pin levels (s_tdata[4:0]), a read-fault mask (s_tdata[9:5]) and a kind bit
// on s_tuser: 0 is a poll, 1 seeds the debounce state from the current levels
// so that contacts already held at start-up do not report. A poll visits the
// active contacts round-robin from a rotating start position, one contact per
// clock through a single sample-and-settle unit, and stops at the first
// contact whose agreement counter confirms a release-to-press edge; the next
// poll then starts just past that contact. Every request yields exactly one
// result on m_tdata: valid flag, direction (from direction_map) and contact
// index, with direction and index zero when no press was found. The block
// accepts a new request as soon as the previous one is finished, even while
// its result still sits unclaimed in the output register; it only stalls
// when a second result has nowhere to go. Configuration is written through
// cfg_we, cfg_addr and cfg_wdata; the user must write it only while no
// request is in flight, as the block itself does not enforce this.

module debounced_button_scanner
    import dbs_pkg::*;
#(
    parameter int NUM_SOURCES   = 5,
    parameter int AGREE_SAMPLES = 3
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_AW-1:0]    cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // Request stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // raw_levels[4:0], read_fault[9:5]
    input  wire logic                 s_tuser,   // kind
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata    // event_valid[0], event_dir[1],
                                                 // event_source[4:2]
);

    dbs_cmd_t    cmd;
    dbs_status_t stat;

    // Padding bits of the request payload carry nothing.
    logic [S_DATA_W-2*LINE_N-1:0] unused_pad;
    assign unused_pad = s_tdata[S_DATA_W-1:2*LINE_N];

    dbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dbs_datapath #(
        .NUM_SOURCES   (NUM_SOURCES),
        .AGREE_SAMPLES (AGREE_SAMPLES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_kind   (s_tuser),
        .in_levels (s_tdata[LINE_N-1:0]),
        .in_fault  (s_tdata[2*LINE_N-1:LINE_N]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule : debounced_button_scanner

`default_nettype wire
